>>> design/secs1_block_link_controller_top_assert.svh
// Assertion macros shared by the link controller modules.
`ifndef SECS1_BLOCK_LINK_CONTROLLER_TOP_ASSERT_SVH
`define SECS1_BLOCK_LINK_CONTROLLER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define S1_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the following cycle.
`define S1_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

>>> design/s1blc_pkg.sv
// ---------------------------------------------------------------------------
// s1blc_pkg
// Types and constants shared by the SECS-I block link controller modules.
// ---------------------------------------------------------------------------
package s1blc_pkg;

  localparam logic [7:0] C_EOT = 8'd4;
  localparam logic [7:0] C_ENQ = 8'd5;
  localparam logic [7:0] C_ACK = 8'd6;
  localparam logic [7:0] C_NAK = 8'd21;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_SEND = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SP_IDLE     = 2'd0,
    SP_WAIT_EOT = 2'd1,
    SP_WAIT_ACK = 2'd2,
    SP_COLLIDED = 2'd3
  } send_phase_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_ACCEPTED  = 4'd1,
    EV_DUPLICATE = 4'd2,
    EV_SUM_ERR   = 4'd3,
    EV_SIZE_ERR  = 4'd4,
    EV_REJECTED  = 4'd5,
    EV_TX_BLOCK  = 4'd6,
    EV_SEND_DONE = 4'd7,
    EV_SEND_FAIL = 4'd8,
    EV_COLLISION = 4'd9
  } event_t;

  localparam logic [1:0] CFG_IS_HOST     = 2'd0;
  localparam logic [1:0] CFG_T2_TICKS    = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

  // Classified item passed from the front end to the engine.
  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic [7:0] send_length;
    logic       upper_reject;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    event_t     event_res;
  } result_t;

endpackage

>>> design/s1blc_front.sv
// ---------------------------------------------------------------------------
// s1blc_front
// Accepts input items and holds them in a two-entry queue for the engine.
// ---------------------------------------------------------------------------
module s1blc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  s1blc_pkg::item_t  in_item,
  output logic              q_valid,
  input  logic              q_ready,
  output s1blc_pkg::item_t  q_item
);

  s1blc_pkg::item_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  `include "secs1_block_link_controller_top_assert.svh"
  `S1_ASSERT_IMPL(a_no_overflow, clk, rst, count == 2'd2, !push)
  `S1_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count != 2'd3)
  `S1_ASSERT_NEXT(a_pop_only, clk, rst, !push && !pop && count == 2'd1, count == 2'd1)

endmodule

>>> design/s1blc_engine.sv
// ---------------------------------------------------------------------------
// s1blc_engine
// Link protocol: one item per cycle unless output stalls; result registered.
// ---------------------------------------------------------------------------
module s1blc_engine #(
  parameter int MAX_BLOCK_BYTES = 254,
  parameter int HEADER_BYTES    = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               is_host,
  input  logic [15:0]        t2_ticks,
  input  logic [3:0]         retry_limit,
  input  logic               q_valid,
  output logic               q_ready,
  input  s1blc_pkg::item_t   q_item,
  output logic               res_valid,
  input  logic               res_ready,
  output s1blc_pkg::result_t res
);

  localparam int HW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  logic                   receive_phase, receive_phase_next;
  s1blc_pkg::send_phase_t send_phase, send_phase_next;
  logic                   send_pending, send_pending_next;
  logic [8:0]             bytes_seen, bytes_seen_next;
  logic [7:0]             expected_length, expected_length_next;
  logic [15:0]            running_sum, running_sum_next;
  logic [7:0]             sum_high_byte, sum_high_byte_next;
  logic [15:0]            timeout_counter, timeout_counter_next;
  logic [3:0]             retry_count, retry_count_next;
  logic [7:0]             current_header  [HEADER_BYTES];
  logic [7:0]             previous_header [HEADER_BYTES];
  logic                   hdr_wr;
  logic                   hdr_copy;
  logic                   hdr_equal;
  logic                   take;
  s1blc_pkg::result_t     r;
  logic                   ctl;
  logic [7:0]             b;
  logic [15:0]            lim;
  logic [15:0]            tcount;
  logic [8:0]             idx9;

  assign q_ready = !res_valid || res_ready;
  assign take    = q_valid && q_ready;
  assign b       = q_item.rx_byte;
  assign lim     = (t2_ticks == 16'd0) ? 16'd1 : t2_ticks;
  assign idx9    = bytes_seen - 9'd1;

  always_comb begin
    hdr_equal = 1'b1;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (current_header[i] != previous_header[i]) begin
        hdr_equal = 1'b0;
      end
    end
  end

  always_comb begin
    receive_phase_next   = receive_phase;
    send_phase_next      = send_phase;
    send_pending_next    = send_pending;
    bytes_seen_next      = bytes_seen;
    expected_length_next = expected_length;
    running_sum_next     = running_sum;
    sum_high_byte_next   = sum_high_byte;
    timeout_counter_next = timeout_counter;
    retry_count_next     = retry_count;
    hdr_wr               = 1'b0;
    hdr_copy             = 1'b0;
    r                    = '0;
    r.event_res          = s1blc_pkg::EV_NONE;
    ctl                  = 1'b0;
    tcount               = timeout_counter + 16'd1;
    case (q_item.op)
      s1blc_pkg::OP_BYTE: begin
        if (!receive_phase) begin
          ctl = (b == s1blc_pkg::C_ENQ) || (b == s1blc_pkg::C_EOT) ||
                (b == s1blc_pkg::C_ACK) || (b == s1blc_pkg::C_NAK);
        end else begin
          ctl = (bytes_seen == 9'd0) && ((b == s1blc_pkg::C_ENQ) ||
                (b == s1blc_pkg::C_EOT) || (b == s1blc_pkg::C_ACK));
        end
        if (ctl) begin
          if (b == s1blc_pkg::C_ENQ) begin
            if (is_host) begin
              r.tx_valid = 1'b1;
              r.tx_byte  = s1blc_pkg::C_EOT;
              receive_phase_next = 1'b1;
              bytes_seen_next    = 9'd0;
              running_sum_next   = 16'd0;
              if (send_phase == s1blc_pkg::SP_WAIT_EOT) begin
                send_phase_next = s1blc_pkg::SP_COLLIDED;
                r.event_res     = s1blc_pkg::EV_COLLISION;
              end
            end else if (send_phase != s1blc_pkg::SP_IDLE || send_pending) begin
              // The equipment side keeps its own send ahead of the host.
            end else if (!receive_phase) begin
              r.tx_valid = 1'b1;
              r.tx_byte  = s1blc_pkg::C_EOT;
              receive_phase_next = 1'b1;
              bytes_seen_next    = 9'd0;
              running_sum_next   = 16'd0;
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte  = s1blc_pkg::C_NAK;
            end
          end else if (b == s1blc_pkg::C_EOT) begin
            if (send_phase == s1blc_pkg::SP_WAIT_EOT) begin
              send_phase_next      = s1blc_pkg::SP_WAIT_ACK;
              timeout_counter_next = 16'd0;
              r.event_res          = s1blc_pkg::EV_TX_BLOCK;
            end
          end else if (b == s1blc_pkg::C_ACK) begin
            if (send_phase == s1blc_pkg::SP_WAIT_ACK) begin
              send_phase_next = s1blc_pkg::SP_IDLE;
              r.event_res     = s1blc_pkg::EV_SEND_DONE;
            end
          end
        end else if (receive_phase) begin
          if (bytes_seen == 9'd0) begin
            expected_length_next = b;
            if (b < 8'(HEADER_BYTES) || b > 8'(MAX_BLOCK_BYTES)) begin
              receive_phase_next = 1'b0;
              r.tx_valid  = 1'b1;
              r.tx_byte   = s1blc_pkg::C_NAK;
              r.event_res = s1blc_pkg::EV_SIZE_ERR;
            end else begin
              bytes_seen_next  = 9'd1;
              running_sum_next = 16'd0;
            end
          end else if (bytes_seen <= {1'b0, expected_length}) begin
            hdr_wr           = (idx9 < 9'(HEADER_BYTES));
            running_sum_next = running_sum + {8'd0, b};
            r.payload_valid  = 1'b1;
            r.payload_byte   = b;
            bytes_seen_next  = bytes_seen + 9'd1;
          end else if (bytes_seen == {1'b0, expected_length} + 9'd1) begin
            sum_high_byte_next = b;
            bytes_seen_next    = bytes_seen + 9'd1;
          end else begin
            receive_phase_next = 1'b0;
            bytes_seen_next    = 9'd0;
            r.tx_valid         = 1'b1;
            if ({sum_high_byte, b} != running_sum) begin
              r.tx_byte   = s1blc_pkg::C_NAK;
              r.event_res = s1blc_pkg::EV_SUM_ERR;
            end else if (hdr_equal) begin
              r.tx_byte   = s1blc_pkg::C_ACK;
              r.event_res = s1blc_pkg::EV_DUPLICATE;
            end else begin
              hdr_copy = 1'b1;
              if (q_item.upper_reject) begin
                r.tx_byte   = s1blc_pkg::C_NAK;
                r.event_res = s1blc_pkg::EV_REJECTED;
              end else begin
                r.tx_byte   = s1blc_pkg::C_ACK;
                r.event_res = s1blc_pkg::EV_ACCEPTED;
              end
            end
          end
        end
      end
      s1blc_pkg::OP_TICK: begin
        if (send_phase == s1blc_pkg::SP_WAIT_EOT || send_phase == s1blc_pkg::SP_WAIT_ACK) begin
          timeout_counter_next = tcount;
          if (tcount >= lim) begin
            if (retry_count >= retry_limit) begin
              send_phase_next      = s1blc_pkg::SP_IDLE;
              timeout_counter_next = 16'd0;
              r.event_res          = s1blc_pkg::EV_SEND_FAIL;
            end else begin
              retry_count_next     = retry_count + 4'd1;
              send_phase_next      = s1blc_pkg::SP_WAIT_EOT;
              timeout_counter_next = 16'd0;
              r.tx_valid           = 1'b1;
              r.tx_byte            = s1blc_pkg::C_ENQ;
            end
          end
        end else if (!receive_phase && send_phase == s1blc_pkg::SP_COLLIDED) begin
          send_phase_next      = s1blc_pkg::SP_WAIT_EOT;
          timeout_counter_next = 16'd0;
          r.tx_valid           = 1'b1;
          r.tx_byte            = s1blc_pkg::C_ENQ;
        end else if (!receive_phase && send_pending && send_phase == s1blc_pkg::SP_IDLE) begin
          send_pending_next    = 1'b0;
          send_phase_next      = s1blc_pkg::SP_WAIT_EOT;
          timeout_counter_next = 16'd0;
          retry_count_next     = 4'd0;
          r.tx_valid           = 1'b1;
          r.tx_byte            = s1blc_pkg::C_ENQ;
        end
      end
      s1blc_pkg::OP_SEND: begin
        if (q_item.send_length > 8'(MAX_BLOCK_BYTES) ||
            send_phase != s1blc_pkg::SP_IDLE || send_pending) begin
          r.event_res = s1blc_pkg::EV_SEND_FAIL;
        end else if (receive_phase) begin
          send_pending_next = 1'b1;
        end else begin
          send_phase_next      = s1blc_pkg::SP_WAIT_EOT;
          timeout_counter_next = 16'd0;
          retry_count_next     = 4'd0;
          r.tx_valid           = 1'b1;
          r.tx_byte            = s1blc_pkg::C_ENQ;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_phase   <= 1'b0;
      send_phase      <= s1blc_pkg::SP_IDLE;
      send_pending    <= 1'b0;
      bytes_seen      <= 9'd0;
      expected_length <= 8'd0;
      running_sum     <= 16'd0;
      sum_high_byte   <= 8'd0;
      timeout_counter <= 16'd0;
      retry_count     <= 4'd0;
      res_valid       <= 1'b0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        previous_header[i] <= 8'd0;
      end
    end else begin
      if (take) begin
        receive_phase   <= receive_phase_next;
        send_phase      <= send_phase_next;
        send_pending    <= send_pending_next;
        bytes_seen      <= bytes_seen_next;
        expected_length <= expected_length_next;
        running_sum     <= running_sum_next;
        sum_high_byte   <= sum_high_byte_next;
        timeout_counter <= timeout_counter_next;
        retry_count     <= retry_count_next;
        if (hdr_copy) begin
          for (int i = 0; i < HEADER_BYTES; i++) begin
            previous_header[i] <= current_header[i];
          end
        end
      end
      if (take) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= r;
      if (hdr_wr) begin
        current_header[idx9[HW-1:0]] <= b;
      end
    end
  end

  `include "secs1_block_link_controller_top_assert.svh"
  `S1_ASSERT_IMPL(a_pending_only_idle, clk, rst, send_pending, send_phase == s1blc_pkg::SP_IDLE)
  `S1_ASSERT_IMPL(a_hold_on_stall, clk, rst, res_valid && !res_ready, !q_ready)
  `S1_ASSERT_IMPL(a_rx_idle_count, clk, rst, !receive_phase, bytes_seen == 9'd0)

endmodule

>>> design/secs1_block_link_controller_top.sv
// ---------------------------------------------------------------------------
// secs1_block_link_controller_top
// SECS-I link handshake: ENQ/EOT/ACK/NAK exchange, block checks, send retry.
// ---------------------------------------------------------------------------
// Each accepted item (received byte, timer tick or send request) yields
// exactly one result; the item passes through the input queue and the
// result through the engine's result register before it is offered.
// One item is taken per cycle while the output is not stalled; the whole
// protocol step is combinational in the engine, and a two-entry queue between
// the input side and the engine absorbs an output stall until the queue is full.
// Configuration writes are taken at once and are meant to happen only while
// the block is idle.
module secs1_block_link_controller_top #(
  parameter int MAX_BLOCK_BYTES = 254,
  parameter int HEADER_BYTES    = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] rx_byte,
  input  logic [7:0] send_length,
  input  logic       upper_reject,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic [3:0] event_res
);

  logic               is_host;
  logic [15:0]        t2_ticks;
  logic [3:0]         retry_limit;
  s1blc_pkg::item_t   in_item;
  s1blc_pkg::item_t   q_item;
  logic               q_valid;
  logic               q_ready;
  s1blc_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_host     <= 1'b0;
      t2_ticks    <= 16'd10000;
      retry_limit <= 4'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        s1blc_pkg::CFG_IS_HOST:     is_host     <= cfg_data[0];
        s1blc_pkg::CFG_T2_TICKS:    t2_ticks    <= cfg_data;
        s1blc_pkg::CFG_RETRY_LIMIT: retry_limit <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.op           = s1blc_pkg::op_t'(op);
  assign in_item.rx_byte      = rx_byte;
  assign in_item.send_length  = send_length;
  assign in_item.upper_reject = upper_reject;

  s1blc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  s1blc_engine #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
    .HEADER_BYTES    (HEADER_BYTES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .is_host     (is_host),
    .t2_ticks    (t2_ticks),
    .retry_limit (retry_limit),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .res         (res)
  );

  assign tx_valid      = res.tx_valid;
  assign tx_byte       = res.tx_byte;
  assign payload_valid = res.payload_valid;
  assign payload_byte  = res.payload_byte;
  assign event_res     = res.event_res;

endmodule

>>> verif/tb_secs1_block_link_controller_top.sv
// ---------------------------------------------------------------------------
// tb_secs1_block_link_controller_top
// Self-checking bench for the SECS-I link controller. A queue-fed driver
// sends received bytes, ticks and send requests. An in-bench model of the
// link handshake predicts one result per transfer, and a monitor compares
// each result field by field. The run steps through several register
// settings and idling patterns.
// ---------------------------------------------------------------------------
module tb_secs1_block_link_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR = 10;
  localparam int MAXLEN = 254;
  localparam int LIMIT = 400000;

  typedef struct {
    s1blc_pkg::op_t op;
    logic [7:0]     b;
    logic [7:0]     len;
    logic           rej;
  } stim_t;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic in_valid = 0, in_ready;
  logic [1:0] op = 0;
  logic [7:0] rx_byte = 0, send_length = 0;
  logic upper_reject = 0;
  logic out_valid, out_ready = 0;
  logic tx_valid, payload_valid;
  logic [7:0] tx_byte, payload_byte;
  logic [3:0] event_res;

  secs1_block_link_controller_top DUT (.*);

  stim_t              pending_items[$];
  s1blc_pkg::result_t expected_results[$];
  int mismatches = 0, cycle_count = 0, idle_mode = 0, blocks_sent = 0, sends_sent = 0;

  // Model state of the link.
  logic                   m_host;
  logic [15:0]            m_t2;
  logic [3:0]             m_retry_lim;
  logic                   rx_active, tx_held;
  s1blc_pkg::send_phase_t tx_phase;
  int          byte_count, block_len, sum_acc, sum_hi, t2_count, retries;
  logic [7:0]  hdr_cur[HDR], hdr_prev[HDR];
  logic [7:0]  gen_hdr[HDR];

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void start_enq(ref s1blc_pkg::result_t r, input bit fresh);
    tx_phase = s1blc_pkg::SP_WAIT_EOT;
    t2_count = 0;
    if (fresh) retries = 0;
    r.tx_valid = 1;
    r.tx_byte = s1blc_pkg::C_ENQ;
  endfunction

  function automatic s1blc_pkg::result_t link_step(stim_t s);
    s1blc_pkg::result_t r;
    bit ctl, same;
    int lim, got;
    r = '0;
    r.event_res = s1blc_pkg::EV_NONE;
    case (s.op)
      s1blc_pkg::OP_BYTE: begin
        if (!rx_active)
          ctl = s.b inside {s1blc_pkg::C_ENQ, s1blc_pkg::C_EOT, s1blc_pkg::C_ACK,
                            s1blc_pkg::C_NAK};
        else
          ctl = byte_count == 0 &&
                (s.b inside {s1blc_pkg::C_ENQ, s1blc_pkg::C_EOT, s1blc_pkg::C_ACK});
        if (ctl) begin
          if (s.b == s1blc_pkg::C_ENQ) begin
            if (m_host) begin
              r.tx_valid = 1; r.tx_byte = s1blc_pkg::C_EOT;
              rx_active = 1; byte_count = 0; sum_acc = 0;
              if (tx_phase == s1blc_pkg::SP_WAIT_EOT) begin
                tx_phase = s1blc_pkg::SP_COLLIDED;
                r.event_res = s1blc_pkg::EV_COLLISION;
              end
            end else if (tx_phase != s1blc_pkg::SP_IDLE || tx_held) begin
              // Own send wins on the equipment side.
            end else if (!rx_active) begin
              r.tx_valid = 1; r.tx_byte = s1blc_pkg::C_EOT;
              rx_active = 1; byte_count = 0; sum_acc = 0;
            end else begin
              r.tx_valid = 1; r.tx_byte = s1blc_pkg::C_NAK;
            end
          end else if (s.b == s1blc_pkg::C_EOT) begin
            if (tx_phase == s1blc_pkg::SP_WAIT_EOT) begin
              tx_phase = s1blc_pkg::SP_WAIT_ACK; t2_count = 0;
              r.event_res = s1blc_pkg::EV_TX_BLOCK;
            end
          end else if (s.b == s1blc_pkg::C_ACK) begin
            if (tx_phase == s1blc_pkg::SP_WAIT_ACK) begin
              tx_phase = s1blc_pkg::SP_IDLE; r.event_res = s1blc_pkg::EV_SEND_DONE;
            end
          end
        end else if (rx_active) begin
          if (byte_count == 0) begin
            block_len = s.b;
            if (s.b < HDR || s.b > MAXLEN) begin
              rx_active = 0;
              r.tx_valid = 1; r.tx_byte = s1blc_pkg::C_NAK;
              r.event_res = s1blc_pkg::EV_SIZE_ERR;
            end else begin
              byte_count = 1; sum_acc = 0;
            end
          end else if (byte_count <= block_len) begin
            if (byte_count - 1 < HDR) hdr_cur[byte_count - 1] = s.b;
            sum_acc = (sum_acc + s.b) & 16'hFFFF;
            r.payload_valid = 1; r.payload_byte = s.b;
            byte_count++;
          end else if (byte_count == block_len + 1) begin
            sum_hi = s.b;
            byte_count++;
          end else begin
            got = (sum_hi << 8) | s.b;
            rx_active = 0; byte_count = 0;
            same = 1;
            for (int i = 0; i < HDR; i++) if (hdr_prev[i] != hdr_cur[i]) same = 0;
            r.tx_valid = 1;
            if (got != sum_acc) begin
              r.tx_byte = s1blc_pkg::C_NAK; r.event_res = s1blc_pkg::EV_SUM_ERR;
            end else if (same) begin
              r.tx_byte = s1blc_pkg::C_ACK; r.event_res = s1blc_pkg::EV_DUPLICATE;
            end else begin
              hdr_prev = hdr_cur;
              r.tx_byte = s.rej ? s1blc_pkg::C_NAK : s1blc_pkg::C_ACK;
              r.event_res = s.rej ? s1blc_pkg::EV_REJECTED : s1blc_pkg::EV_ACCEPTED;
            end
          end
        end
      end
      s1blc_pkg::OP_TICK: begin
        if (tx_phase == s1blc_pkg::SP_WAIT_EOT || tx_phase == s1blc_pkg::SP_WAIT_ACK) begin
          lim = (m_t2 == 0) ? 1 : m_t2;
          t2_count++;
          if (t2_count >= lim) begin
            if (retries >= m_retry_lim) begin
              tx_phase = s1blc_pkg::SP_IDLE; t2_count = 0;
              r.event_res = s1blc_pkg::EV_SEND_FAIL;
            end else begin
              retries = (retries + 1) & 4'hF;
              start_enq(r, 0);
            end
          end
        end else if (!rx_active && tx_phase == s1blc_pkg::SP_COLLIDED) begin
          start_enq(r, 0);
        end else if (!rx_active && tx_held && tx_phase == s1blc_pkg::SP_IDLE) begin
          tx_held = 0;
          start_enq(r, 1);
        end
      end
      s1blc_pkg::OP_SEND: begin
        if (s.len > MAXLEN || tx_phase != s1blc_pkg::SP_IDLE || tx_held)
          r.event_res = s1blc_pkg::EV_SEND_FAIL;
        else if (rx_active) tx_held = 1;
        else start_enq(r, 1);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: one transfer per handshake, random gaps per idle_mode.
  always @(posedge clk) begin
    stim_t nxt;
    bit gap;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(link_step('{s1blc_pkg::op_t'(op), rx_byte, send_length,
                                               upper_reject}));
      if (!in_valid || in_ready) begin
        gap = (idle_mode == 1) ? ($urandom_range(99) < 79) :
              (idle_mode == 3) ? ($urandom_range(99) < 34) : 0;
        if (pending_items.size() != 0 && !gap) begin
          nxt = pending_items.pop_front();
          in_valid <= 1;
          op <= nxt.op; rx_byte <= nxt.b; send_length <= nxt.len; upper_reject <= nxt.rej;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    s1blc_pkg::result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: ev=%0d", event_res);
        end else begin
          want = expected_results.pop_front();
          if (tx_valid !== want.tx_valid || tx_byte !== want.tx_byte ||
              payload_valid !== want.payload_valid || payload_byte !== want.payload_byte ||
              event_res !== want.event_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp tx %0b/%0d pl %0b/%0d ev %0d, ",
                        "got tx %0b/%0d pl %0b/%0d ev %0d"},
                       want.tx_valid, want.tx_byte, want.payload_valid, want.payload_byte,
                       want.event_res, tx_valid, tx_byte, payload_valid, payload_byte,
                       event_res);
          end
        end
      end
      out_ready <= (idle_mode == 2) ? ($urandom_range(99) >= 79) :
                   (idle_mode == 3) ? ($urandom_range(99) >= 34) : 1'b1;
    end
  end

  task automatic add(s1blc_pkg::op_t o, logic [7:0] b = 0, logic [7:0] len = 0,
                     logic rej = 0);
    pending_items.push_back('{o, b, len, rej});
  endtask

  // One received block: ENQ, length, data, two-byte sum.
  task automatic add_block(int len, bit bad_sum, bit reuse_hdr, bit rej);
    int sum;
    logic [7:0] d;
    sum = 0;
    add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_ENQ);
    add(s1blc_pkg::OP_BYTE, len[7:0]);
    for (int i = 0; i < len; i++) begin
      if (i < HDR) begin
        if (!reuse_hdr) gen_hdr[i] = 8'($urandom_range(255));
        d = gen_hdr[i];
      end else begin
        d = 8'($urandom_range(255));
      end
      sum = (sum + d) & 16'hFFFF;
      add(s1blc_pkg::OP_BYTE, d, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    if (bad_sum) sum = sum ^ (1 << $urandom_range(15));
    add(s1blc_pkg::OP_BYTE, sum[15:8]);
    add(s1blc_pkg::OP_BYTE, sum[7:0], 0, rej);
    blocks_sent++;
  endtask

  task automatic add_send(int t2);
    add(s1blc_pkg::OP_SEND, 0,
        ($urandom_range(49) == 0) ? 8'd255 : 8'($urandom_range(254)));
    repeat ($urandom_range(t2 < 4 ? t2 + 1 : 3)) add(s1blc_pkg::OP_TICK);
    if ($urandom_range(9) != 0) add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_EOT);
    repeat ($urandom_range(2)) add(s1blc_pkg::OP_TICK);
    if ($urandom_range(9) != 0) add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_ACK);
    sends_sent++;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      s1blc_pkg::CFG_IS_HOST:     m_host = val[0];
      s1blc_pkg::CFG_T2_TICKS:    m_t2 = val;
      s1blc_pkg::CFG_RETRY_LIMIT: m_retry_lim = val[3:0];
      default: ;
    endcase
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    int sel, t2v, base;
    m_host = 0; m_t2 = 10000; m_retry_lim = 3;
    rx_active = 0; tx_held = 0; tx_phase = s1blc_pkg::SP_IDLE;
    byte_count = 0; block_len = 0; sum_acc = 0; sum_hi = 0; t2_count = 0; retries = 0;
    for (int i = 0; i < HDR; i++) begin
      hdr_prev[i] = 0; hdr_cur[i] = 0; gen_hdr[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      idle_mode = ph % 4;
      case (ph % 4)
        0: t2v = 3;
        1: t2v = 1;
        2: t2v = 65535;
        default: t2v = $urandom_range(2, 6);
      endcase
      write_reg(s1blc_pkg::CFG_IS_HOST, ph[1] ? 16'd1 : 16'd0);
      write_reg(s1blc_pkg::CFG_T2_TICKS, t2v[15:0]);
      write_reg(s1blc_pkg::CFG_RETRY_LIMIT,
                (ph % 3 == 0) ? 16'd0 : (ph % 3 == 1) ? 16'd15 : 16'd2);

      if (ph == 0 || ph == 2) begin
        // Directed corners: unknown op, ignored bytes, bad lengths, busy sends.
        add(s1blc_pkg::OP_NONE, 8'hFF, 8'hFF, 1);
        add(s1blc_pkg::OP_BYTE, 8'h00);
        add(s1blc_pkg::OP_BYTE, 8'hFF);
        add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_NAK);
        add(s1blc_pkg::OP_SEND, 0, 8'd255);
        add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_ENQ); add(s1blc_pkg::OP_BYTE, 8'd9);
        add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_ENQ); add(s1blc_pkg::OP_BYTE, 8'd255);
        add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_ENQ); add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_ENQ);
        add(s1blc_pkg::OP_SEND, 0, 8'd254);   // held while receiving
        add(s1blc_pkg::OP_SEND, 0, 8'd0);     // busy
        add(s1blc_pkg::OP_BYTE, 8'd10);
        repeat (12) add(s1blc_pkg::OP_BYTE, 8'hFF);
        add(s1blc_pkg::OP_TICK);              // held request goes out
        add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_ENQ);  // collision on host, ignored otherwise
        add(s1blc_pkg::OP_BYTE, s1blc_pkg::C_NAK);
        add(s1blc_pkg::OP_TICK); add(s1blc_pkg::OP_TICK);
        add(s1blc_pkg::OP_TICK); add(s1blc_pkg::OP_TICK);
      end
      if (ph == 2) add_block(MAXLEN, 0, 0, 0);

      // A short random mix per phase; n counts the items actually queued.
      for (int n = 0; n < 10; ) begin
        base = pending_items.size();
        sel = $urandom_range(99);
        if (sel < 45) begin
          add_block($urandom_range(HDR, 16),
                    $urandom_range(99) < 15, $urandom_range(99) < 25,
                    $urandom_range(99) < 20);
        end else if (sel < 75) begin
          add_send(t2v);
        end else begin
          add(s1blc_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        n += pending_items.size() - base;
      end
    end
    wait_idle();
    $display("covered %0d received blocks and %0d send sequences over 8 register settings",
             blocks_sent, sends_sent);
    $display("idling patterns: none, sender gaps, receiver stalls, both; %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
